/* rtl/core/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, constants and lane types for the quaternion to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int unsigned InW    = 32;  // Q16.16 component width
  localparam int unsigned ProdW  = 64;  // full product width
  localparam int unsigned NumW   = 66;  // signed matrix numerator width
  localparam int unsigned DenW   = 65;  // unsigned squared norm width
  localparam int unsigned RemW   = 66;  // divider partial remainder width
  localparam int unsigned QW     = 32;  // quotient bits incl. round bit
  localparam int unsigned OutW   = 32;  // Q1.30 entry width
  localparam int unsigned NLanes = 9;   // matrix entries
  localparam int unsigned NProd  = 10;  // distinct products

  localparam logic [OutW-1:0] OneQ30 = 32'h4000_0000;

  // product slots
  localparam int unsigned PW2 = 0;
  localparam int unsigned PX2 = 1;
  localparam int unsigned PY2 = 2;
  localparam int unsigned PZ2 = 3;
  localparam int unsigned PXY = 4;
  localparam int unsigned PWZ = 5;
  localparam int unsigned PXZ = 6;
  localparam int unsigned PWY = 7;
  localparam int unsigned PYZ = 8;
  localparam int unsigned PWX = 9;

  typedef logic signed [NProd-1:0][ProdW-1:0] prod_arr_t;
  typedef logic        [NLanes-1:0][RemW-1:0]  rem_arr_t;
  typedef logic        [NLanes-1:0][QW-1:0]    q_arr_t;

  // control traveling with each item through the divider
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [NLanes-1:0] neg;
  } lane_ctl_t;

endpackage

/* rtl/core/qrm_mult.sv */
// ----------------------------------------------------------------------------
// qrm_mult
// First stage: the ten component products, registered.
// ----------------------------------------------------------------------------
module qrm_mult (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [qrm_pkg::InW-1:0]  w_i,
  input  logic signed [qrm_pkg::InW-1:0]  x_i,
  input  logic signed [qrm_pkg::InW-1:0]  y_i,
  input  logic signed [qrm_pkg::InW-1:0]  z_i,
  output logic                            valid_o,
  output logic                            zero_o,
  output qrm_pkg::prod_arr_t              prod_o
);

  logic               valid_q;
  logic               zero_q;
  qrm_pkg::prod_arr_t prod_d, prod_q;

  // products
  always_comb begin
    prod_d[qrm_pkg::PW2] = w_i * w_i;
    prod_d[qrm_pkg::PX2] = x_i * x_i;
    prod_d[qrm_pkg::PY2] = y_i * y_i;
    prod_d[qrm_pkg::PZ2] = z_i * z_i;
    prod_d[qrm_pkg::PXY] = x_i * y_i;
    prod_d[qrm_pkg::PWZ] = w_i * z_i;
    prod_d[qrm_pkg::PXZ] = x_i * z_i;
    prod_d[qrm_pkg::PWY] = w_i * y_i;
    prod_d[qrm_pkg::PYZ] = y_i * z_i;
    prod_d[qrm_pkg::PWX] = w_i * x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    zero_q <= (w_i == '0) && (x_i == '0) && (y_i == '0) && (z_i == '0);
  end

  assign valid_o = valid_q;
  assign zero_o  = zero_q;
  assign prod_o  = prod_q;

endmodule

/* rtl/core/qrm_combine.sv */
// ----------------------------------------------------------------------------
// qrm_combine
// Forms the squared norm and the nine matrix numerators, then splits each
// numerator into sign and magnitude. Two register stages.
// ----------------------------------------------------------------------------
module qrm_combine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          zero_i,
  input  qrm_pkg::prod_arr_t            prod_i,
  output qrm_pkg::lane_ctl_t            ctl_o,
  output logic [qrm_pkg::DenW-1:0]      den_o,
  output qrm_pkg::rem_arr_t             rem_o
);

  typedef logic signed [qrm_pkg::NumW-1:0] num_t;

  num_t w2, x2, y2, z2, xy, wz, xz, wy, yz, wx;
  num_t n2_d, n2_q;
  num_t [qrm_pkg::NLanes-1:0] nm_d, nm_q;
  logic valid1_q, zero1_q;

  qrm_pkg::lane_ctl_t ctl_d, ctl_q;
  qrm_pkg::rem_arr_t  mag_d, mag_q;
  logic [qrm_pkg::DenW-1:0] den_q;

  // sign extend products (a packed array element reads as unsigned)
  always_comb begin
    w2 = num_t'($signed(prod_i[qrm_pkg::PW2]));
    x2 = num_t'($signed(prod_i[qrm_pkg::PX2]));
    y2 = num_t'($signed(prod_i[qrm_pkg::PY2]));
    z2 = num_t'($signed(prod_i[qrm_pkg::PZ2]));
    xy = num_t'($signed(prod_i[qrm_pkg::PXY]));
    wz = num_t'($signed(prod_i[qrm_pkg::PWZ]));
    xz = num_t'($signed(prod_i[qrm_pkg::PXZ]));
    wy = num_t'($signed(prod_i[qrm_pkg::PWY]));
    yz = num_t'($signed(prod_i[qrm_pkg::PYZ]));
    wx = num_t'($signed(prod_i[qrm_pkg::PWX]));
  end

  // norm and numerators
  always_comb begin
    n2_d     = (w2 + x2) + (y2 + z2);
    nm_d[0]  = (w2 + x2) - (y2 + z2);
    nm_d[4]  = (w2 + y2) - (x2 + z2);
    nm_d[8]  = (w2 + z2) - (x2 + y2);
    nm_d[1]  = (xy - wz) <<< 1;
    nm_d[3]  = (xy + wz) <<< 1;
    nm_d[2]  = (xz + wy) <<< 1;
    nm_d[6]  = (xz - wy) <<< 1;
    nm_d[5]  = (yz - wx) <<< 1;
    nm_d[7]  = (yz + wx) <<< 1;
  end

  // sign and magnitude
  always_comb begin
    ctl_d.valid = valid1_q;
    ctl_d.zero  = zero1_q;
    for (int l = 0; l < qrm_pkg::NLanes; l++) begin
      ctl_d.neg[l] = nm_q[l][qrm_pkg::NumW-1];
      mag_d[l]     = ctl_d.neg[l] ? qrm_pkg::RemW'(-nm_q[l]) : qrm_pkg::RemW'(nm_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      ctl_q    <= '0;
    end else begin
      valid1_q <= valid_i;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= zero_i;
    n2_q    <= n2_d;
    nm_q    <= nm_d;
    mag_q   <= mag_d;
    den_q   <= n2_q[qrm_pkg::DenW-1:0];
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rem_o = mag_q;

endmodule

/* rtl/core/qrm_div_step.sv */
// ----------------------------------------------------------------------------
// qrm_div_step
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module qrm_div_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qrm_pkg::lane_ctl_t            ctl_i,
  input  logic [qrm_pkg::DenW-1:0]      den_i,
  input  qrm_pkg::rem_arr_t             rem_i,
  input  qrm_pkg::q_arr_t               q_i,
  output qrm_pkg::lane_ctl_t            ctl_o,
  output logic [qrm_pkg::DenW-1:0]      den_o,
  output qrm_pkg::rem_arr_t             rem_o,
  output qrm_pkg::q_arr_t               q_o
);

  logic [qrm_pkg::RemW-1:0] den_ext;
  qrm_pkg::rem_arr_t  rem_d, rem_q;
  qrm_pkg::q_arr_t    q_d, q_q;
  qrm_pkg::lane_ctl_t ctl_q;
  logic [qrm_pkg::DenW-1:0] den_q;
  logic [qrm_pkg::NLanes-1:0] ge;

  assign den_ext = qrm_pkg::RemW'(den_i);

  // compare, subtract, shift
  always_comb begin
    for (int l = 0; l < qrm_pkg::NLanes; l++) begin
      ge[l]    = rem_i[l] >= den_ext;
      rem_d[l] = (ge[l] ? (rem_i[l] - den_ext) : rem_i[l]) << 1;
      q_d[l]   = {q_i[l][qrm_pkg::QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

/* rtl/core/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Each item passes the product register, two combine stages, 32 divider
// steps and the output register before its result strobe rises. The
// receiver cannot stall.
// Throughput: one item per cycle; busy is never raised.
// Reset clears all valid bits; no results are in flight after reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [qrm_pkg::InW-1:0]  quat_w_i,
  input  logic signed [qrm_pkg::InW-1:0]  quat_x_i,
  input  logic signed [qrm_pkg::InW-1:0]  quat_y_i,
  input  logic signed [qrm_pkg::InW-1:0]  quat_z_i,
  output logic                            result_valid_o,
  output logic signed [qrm_pkg::OutW-1:0] m00_o,
  output logic signed [qrm_pkg::OutW-1:0] m01_o,
  output logic signed [qrm_pkg::OutW-1:0] m02_o,
  output logic signed [qrm_pkg::OutW-1:0] m10_o,
  output logic signed [qrm_pkg::OutW-1:0] m11_o,
  output logic signed [qrm_pkg::OutW-1:0] m12_o,
  output logic signed [qrm_pkg::OutW-1:0] m20_o,
  output logic signed [qrm_pkg::OutW-1:0] m21_o,
  output logic signed [qrm_pkg::OutW-1:0] m22_o,
  output logic                            zero_norm_o
);

  localparam int unsigned NSteps = qrm_pkg::QW;

  logic               mult_valid, mult_zero;
  qrm_pkg::prod_arr_t prod;

  qrm_pkg::lane_ctl_t              ctl [NSteps+1];
  logic [qrm_pkg::DenW-1:0]        den [NSteps+1];
  qrm_pkg::rem_arr_t               rem [NSteps+1];
  qrm_pkg::q_arr_t                 qv  [NSteps+1];

  logic [qrm_pkg::NLanes-1:0][qrm_pkg::OutW-1:0] ent_d, ent_q;
  logic [qrm_pkg::OutW:0]          mag;
  logic                            valid_q, zero_q;

  assign busy = 1'b0;

  qrm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .w_i     (quat_w_i),
    .x_i     (quat_x_i),
    .y_i     (quat_y_i),
    .z_i     (quat_z_i),
    .valid_o (mult_valid),
    .zero_o  (mult_zero),
    .prod_o  (prod)
  );

  qrm_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .zero_i  (mult_zero),
    .prod_i  (prod),
    .ctl_o   (ctl[0]),
    .den_o   (den[0]),
    .rem_o   (rem[0])
  );

  assign qv[0] = '0;

  // divider pipeline, one quotient bit per stage
  for (genvar s = 0; s < NSteps; s++) begin : g_div
    qrm_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[s]),
      .den_i  (den[s]),
      .rem_i  (rem[s]),
      .q_i    (qv[s]),
      .ctl_o  (ctl[s+1]),
      .den_o  (den[s+1]),
      .rem_o  (rem[s+1]),
      .q_o    (qv[s+1])
    );
  end

  // round half away, restore sign, identity for a zero quaternion
  always_comb begin
    mag = '0;
    for (int l = 0; l < qrm_pkg::NLanes; l++) begin
      mag = ({1'b0, qv[NSteps][l]} + (qrm_pkg::OutW+1)'(1)) >> 1;
      if (ctl[NSteps].zero) begin
        ent_d[l] = (l % 4 == 0) ? qrm_pkg::OneQ30 : '0;
      end else if (ctl[NSteps].neg[l]) begin
        ent_d[l] = -mag[qrm_pkg::OutW-1:0];
      end else begin
        ent_d[l] = mag[qrm_pkg::OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl[NSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    zero_q <= ctl[NSteps].zero;
  end

  assign result_valid_o = valid_q;
  assign m00_o = ent_q[0];
  assign m01_o = ent_q[1];
  assign m02_o = ent_q[2];
  assign m10_o = ent_q[3];
  assign m11_o = ent_q[4];
  assign m12_o = ent_q[5];
  assign m20_o = ent_q[6];
  assign m21_o = ent_q[7];
  assign m22_o = ent_q[8];
  assign zero_norm_o = zero_q;

endmodule

/* tb/quaternion_to_rotation_matrix_test.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_test
// Drives quaternions into the rotation matrix block under random start gaps,
// predicts each normalized Q1.30 matrix (exact wide arithmetic or typed entry)
// and checks every result field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_test;

  typedef struct {
    logic signed [qrm_pkg::OutW-1:0] m [9];
    logic                            zero;
  } matrix_t;

  typedef struct {
    logic signed [qrm_pkg::InW-1:0] w, x, y, z;
    logic                           known;    // expected matrix typed in below
    matrix_t                        typed;
  } stim_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic signed [qrm_pkg::InW-1:0]  quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic                            result_valid_o;
  logic signed [qrm_pkg::OutW-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o;
  logic signed [qrm_pkg::OutW-1:0] m20_o, m21_o, m22_o;
  logic                            zero_norm_o;

  matrix_t   pending_matrices[$];
  stim_row_t directed_rows[$];
  int        fail_count;
  int        items_sent;
  int        matrices_seen;
  int        zero_seen;

  quaternion_to_rotation_matrix u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit: ~1600 items with gaps through the pipeline, taken many times over
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // rounded |num| * 2^30 / den, signed like num
  function automatic logic signed [qrm_pkg::OutW-1:0] q30_ratio(
      logic signed [qrm_pkg::NumW+1:0] num, logic [qrm_pkg::NumW+1:0] den);
    logic [qrm_pkg::NumW+1:0] mag;
    logic [127:0]             scaled;
    logic [127:0]             quot;
    mag    = num[qrm_pkg::NumW+1] ? -num : num;
    scaled = {mag, 31'b0};
    quot   = (scaled / den + 1) >> 1;
    return num[qrm_pkg::NumW+1] ? -quot[qrm_pkg::OutW-1:0] : quot[qrm_pkg::OutW-1:0];
  endfunction

  // normalized rotation matrix of one quaternion
  function automatic matrix_t rotation_of(
      logic signed [qrm_pkg::InW-1:0] w, logic signed [qrm_pkg::InW-1:0] x,
      logic signed [qrm_pkg::InW-1:0] y, logic signed [qrm_pkg::InW-1:0] z);
    matrix_t                          r;
    logic signed [qrm_pkg::NumW+1:0]  w2, x2, y2, z2, xy, wz, xz, wy, yz, wx, n2;
    w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
    xy = x * y; wz = w * z; xz = x * z; wy = w * y; yz = y * z; wx = w * x;
    n2 = w2 + x2 + y2 + z2;
    r.zero = (n2 == 0);
    if (r.zero) begin
      foreach (r.m[k]) r.m[k] = (k % 4 == 0) ? qrm_pkg::OneQ30 : '0;
      return r;
    end
    r.m[0] = q30_ratio(w2 + x2 - y2 - z2, n2);
    r.m[1] = q30_ratio(2 * (xy - wz), n2);
    r.m[2] = q30_ratio(2 * (xz + wy), n2);
    r.m[3] = q30_ratio(2 * (xy + wz), n2);
    r.m[4] = q30_ratio(w2 - x2 + y2 - z2, n2);
    r.m[5] = q30_ratio(2 * (yz - wx), n2);
    r.m[6] = q30_ratio(2 * (xz - wy), n2);
    r.m[7] = q30_ratio(2 * (yz + wx), n2);
    r.m[8] = q30_ratio(w2 - x2 - y2 + z2, n2);
    return r;
  endfunction

  function automatic matrix_t identity_matrix();
    matrix_t r;
    foreach (r.m[k]) r.m[k] = (k % 4 == 0) ? qrm_pkg::OneQ30 : '0;
    r.zero = 1'b1;
    return r;
  endfunction

  function automatic matrix_t diag_matrix(logic signed [qrm_pkg::OutW-1:0] a,
                                          logic signed [qrm_pkg::OutW-1:0] b,
                                          logic signed [qrm_pkg::OutW-1:0] c);
    matrix_t r;
    foreach (r.m[k]) r.m[k] = '0;
    r.m[0] = a; r.m[4] = b; r.m[8] = c;
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic void add_row(
      logic signed [qrm_pkg::InW-1:0] w, logic signed [qrm_pkg::InW-1:0] x,
      logic signed [qrm_pkg::InW-1:0] y, logic signed [qrm_pkg::InW-1:0] z,
      logic known, matrix_t typed);
    stim_row_t row;
    row.w = w; row.x = x; row.y = y; row.z = z;
    row.known = known; row.typed = typed;
    directed_rows.push_back(row);
  endfunction

  // random component: mostly full range, some small or extreme
  function automatic logic signed [qrm_pkg::InW-1:0] random_component();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed(32'($urandom_range(0, 8))) - 4;
      3, 4:    return $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // one item, waiting out busy and a random idle gap
  task automatic send_item(
      logic signed [qrm_pkg::InW-1:0] w, logic signed [qrm_pkg::InW-1:0] x,
      logic signed [qrm_pkg::InW-1:0] y, logic signed [qrm_pkg::InW-1:0] z,
      logic known, matrix_t typed, bit may_idle);
    while (may_idle && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    quat_w_i <= w; quat_x_i <= x; quat_y_i <= y; quat_z_i <= z;
    pending_matrices.push_back(known ? typed : rotation_of(w, x, y, z));
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    matrix_t                          exp_m;
    logic signed [qrm_pkg::OutW-1:0]  got [9];
    if (rst_ni && result_valid_o) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      matrices_seen++;
      if (pending_matrices.size() == 0) begin
        $error("result with no pending item");
        fail_count++;
      end else begin
        exp_m = pending_matrices.pop_front();
        if (exp_m.zero) zero_seen++;
        foreach (got[k])
          if (got[k] !== exp_m.m[k]) begin
            $error("m%0d%0d expected %0d got %0d", k / 3, k % 3, exp_m.m[k], got[k]);
            fail_count++;
          end
        if (zero_norm_o !== exp_m.zero) begin
          $error("zero_norm expected %0b got %0b", exp_m.zero, zero_norm_o);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    matrix_t none;
    int      waited;
    none       = identity_matrix();
    start      = 1'b0;
    quat_w_i   = '0; quat_x_i = '0; quat_y_i = '0; quat_z_i = '0;
    rst_ni     = 1'b0;
    fail_count = 0; items_sent = 0; matrices_seen = 0; zero_seen = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: zero quaternion, axis rotations, extremes
    add_row(0, 0, 0, 0, 1, identity_matrix());
    add_row(32'sh0001_0000, 0, 0, 0, 1,
            diag_matrix(qrm_pkg::OneQ30, qrm_pkg::OneQ30, qrm_pkg::OneQ30));
    add_row(0, 32'sh0001_0000, 0, 0, 1,
            diag_matrix(qrm_pkg::OneQ30, -qrm_pkg::OneQ30, -qrm_pkg::OneQ30));
    add_row(0, 0, 32'sh0001_0000, 0, 1,
            diag_matrix(-qrm_pkg::OneQ30, qrm_pkg::OneQ30, -qrm_pkg::OneQ30));
    add_row(0, 0, 0, 32'sh0001_0000, 1,
            diag_matrix(-qrm_pkg::OneQ30, -qrm_pkg::OneQ30, qrm_pkg::OneQ30));
    add_row(32'sh8000_0000, 0, 0, 0, 1,
            diag_matrix(qrm_pkg::OneQ30, qrm_pkg::OneQ30, qrm_pkg::OneQ30));
    add_row(0, 0, 0, 0, 1, identity_matrix());
    add_row(1, 0, 0, 0, 1,
            diag_matrix(qrm_pkg::OneQ30, qrm_pkg::OneQ30, qrm_pkg::OneQ30));
    add_row(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, none);
    add_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, none);
    add_row(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, none);
    add_row(-1, -1, -1, -1, 0, none);
    add_row(1, 1, 0, 0, 0, none);
    add_row(1, 2, 3, 4, 0, none);
    add_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, none);
    add_row(0, 1, 0, 32'sh7fff_ffff, 0, none);
    add_row(3, 0, 0, 0, 0, none);
    add_row(1, 1, 1, 0, 0, none);
    add_row(-32'sh0000_b505, 32'sh0000_b505, 0, 0, 0, none);
    foreach (directed_rows[i])
      send_item(directed_rows[i].w, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].z, directed_rows[i].known, directed_rows[i].typed, 0);

    // random part; items 600..999 are sent back to back
    for (int i = 0; i < 1600; i++) begin
      logic signed [qrm_pkg::InW-1:0] w, x, y, z;
      w = random_component(); x = random_component();
      y = random_component(); z = random_component();
      if ($urandom_range(49) == 0) begin
        w = 0; x = 0; y = 0; z = 0;
      end
      send_item(w, x, y, z, 0, none, !(i >= 600 && i < 1000));
    end
    start <= 1'b0;

    // drain
    waited = 0;
    while (pending_matrices.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_matrices.size() != 0) begin
      $error("%0d matrices never arrived", pending_matrices.size());
      fail_count++;
    end
    repeat (40) @(posedge clk_i);

    $display("Sent %0d quaternions, checked %0d matrices (%0d zero-norm).",
             items_sent, matrices_seen, zero_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/qrm_pkg.sv
rtl/core/qrm_mult.sv
rtl/core/qrm_combine.sv
rtl/core/qrm_div_step.sv
rtl/core/quaternion_to_rotation_matrix.sv
tb/quaternion_to_rotation_matrix_test.sv
